@@ sv/fbr_pkg.sv @@
// ----------------------------------------------------------------------------
// fbr_pkg
// Shared types and constants of the framed byte receiver.
// ----------------------------------------------------------------------------
package fbr_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [ByteW-1:0] RstStartByte    = 8'd36;
  localparam logic [ByteW-1:0] RstMaxLength    = 8'd16;
  localparam logic [ByteW-1:0] RstSlotDivide   = 8'd10;
  localparam logic [ByteW-1:0] RstTimeoutSlots = 8'd100;
  localparam logic [ByteW-1:0] StuffByte       = 8'h00;

  typedef enum logic [CfgIdxW-1:0] {
    REG_START_BYTE    = 2'd0,
    REG_MAX_LENGTH    = 2'd1,
    REG_SLOT_DIVIDE   = 2'd2,
    REG_TIMEOUT_SLOTS = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_STRAY      = 3'd1,
    ST_TIMEOUT    = 3'd2,
    ST_ZERO_LEN   = 3'd3,
    ST_TOO_LONG   = 3'd4,
    ST_BAD_STUFF  = 3'd5,
    ST_BAD_CSUM   = 3'd6
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0] start_byte;
    logic [ByteW-1:0] max_length;
    logic [ByteW-1:0] slot_divide;
    logic [ByteW-1:0] timeout_slots;
  } cfg_t;

  typedef struct packed {
    logic             take_byte;
    logic             data_valid;
    logic [ByteW-1:0] data_index;
    logic [ByteW-1:0] data_byte;
    logic             status_valid;
    status_e          status_code;
    logic [ByteW-1:0] frame_length;
  } res_t;

endpackage

@@ sv/fbr_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// fbr_cfg_regs
// Configuration register file written through the cfg channel.
// ----------------------------------------------------------------------------
module fbr_cfg_regs
  import fbr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ByteW-1:0]   cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_START_BYTE:    cfg_d.start_byte    = cfg_data_i;
        REG_MAX_LENGTH:    cfg_d.max_length    = cfg_data_i;
        REG_SLOT_DIVIDE:   cfg_d.slot_divide   = cfg_data_i;
        REG_TIMEOUT_SLOTS: cfg_d.timeout_slots = cfg_data_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte    <= RstStartByte;
      cfg_q.max_length    <= RstMaxLength;
      cfg_q.slot_divide   <= RstSlotDivide;
      cfg_q.timeout_slots <= RstTimeoutSlots;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ sv/fbr_frame_ctrl.sv @@
// ----------------------------------------------------------------------------
// fbr_frame_ctrl
// Frame state machine: slot timing, timeout, length check, stuffing, checksum.
// ----------------------------------------------------------------------------
module fbr_frame_ctrl
  import fbr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             step_i,
  input  logic             byte_ready_i,
  input  logic [ByteW-1:0] rx_byte_i,
  output res_t             res_o
);

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_LENGTH = 3'd1,
    PH_DATA   = 3'd2,
    PH_ZERO   = 3'd3,
    PH_CHECK  = 3'd4
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] slot_q, slot_d;
  logic [ByteW-1:0] wait_q, wait_d;
  logic [ByteW-1:0] seen_q, seen_d;
  logic [ByteW-1:0] len_q, len_d;
  logic [ByteW-1:0] sum_q, sum_d;
  logic [ByteW-1:0] slot_inc, wait_inc, seen_inc;
  res_t             res;

  assign slot_inc = slot_q + 8'd1;
  assign wait_inc = wait_q + 8'd1;
  assign seen_inc = seen_q + 8'd1;

  always_comb begin
    phase_d = phase_q;
    slot_d  = slot_q;
    wait_d  = wait_q;
    seen_d  = seen_q;
    len_d   = len_q;
    sum_d   = sum_q;
    res     = '0;
    if (phase_q == PH_START) begin
      if (byte_ready_i) begin
        res.take_byte = 1'b1;
        if (rx_byte_i == cfg_i.start_byte) begin
          wait_d  = '0;
          phase_d = PH_LENGTH;
        end else begin
          res.status_valid = 1'b1;
          res.status_code  = ST_STRAY;
        end
      end
    end else if (slot_inc < cfg_i.slot_divide) begin
      slot_d = slot_inc;
    end else begin
      slot_d = '0;
      wait_d = wait_inc;
      if (wait_inc >= cfg_i.timeout_slots) begin
        res.status_valid = 1'b1;
        res.status_code  = ST_TIMEOUT;
        phase_d          = PH_START;
      end else if (byte_ready_i) begin
        res.take_byte = 1'b1;
        wait_d        = '0;
        unique case (phase_q)
          PH_LENGTH: begin
            len_d = rx_byte_i;
            if (rx_byte_i == '0) begin
              res.status_valid = 1'b1;
              res.status_code  = ST_ZERO_LEN;
              phase_d          = PH_START;
            end else if (rx_byte_i > cfg_i.max_length) begin
              res.status_valid = 1'b1;
              res.status_code  = ST_TOO_LONG;
              phase_d          = PH_START;
            end else begin
              seen_d  = '0;
              sum_d   = '0;
              phase_d = PH_DATA;
            end
          end
          PH_DATA: begin
            res.data_valid = 1'b1;
            res.data_index = seen_q;
            res.data_byte  = rx_byte_i;
            sum_d          = sum_q + rx_byte_i;
            seen_d         = seen_inc;
            if (rx_byte_i == cfg_i.start_byte) begin
              phase_d = PH_ZERO;
            end else if (seen_inc == len_q) begin
              phase_d = PH_CHECK;
            end
          end
          PH_ZERO: begin
            if (rx_byte_i != StuffByte) begin
              res.status_valid = 1'b1;
              res.status_code  = ST_BAD_STUFF;
              phase_d          = PH_START;
            end else if (seen_q < len_q) begin
              phase_d = PH_DATA;
            end else begin
              phase_d = PH_CHECK;
            end
          end
          PH_CHECK: begin
            res.status_valid = 1'b1;
            res.status_code  = (rx_byte_i == sum_q) ? ST_OK : ST_BAD_CSUM;
            phase_d          = PH_START;
          end
          default: phase_d = PH_START;
        endcase
      end
    end
    res.frame_length = len_d;
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      slot_q  <= '0;
      wait_q  <= '0;
      seen_q  <= '0;
      len_q   <= '0;
      sum_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      slot_q  <= slot_d;
      wait_q  <= wait_d;
      seen_q  <= seen_d;
      len_q   <= len_d;
      sum_q   <= sum_d;
    end
  end

endmodule

@@ sv/framed_byte_receiver_unit.sv @@
// ----------------------------------------------------------------------------
// framed_byte_receiver_unit
// Receives start-byte framed, zero-stuffed, sum-checked frames one tick per
// item.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+--------------------------
//  in       | input     | in_valid_i / in_stall_o   | byte_ready_i, rx_byte_i
//  out      | output    | out_valid_o / out_stall_i | take_byte_o .. frame_length_o
//  cfg      | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item per cycle sustained when unstalled. Each item passes the input register,
// then the frame state machine into the result register. The result register and
// the input register advance together, so a new item is taken while a result waits
// as long as the result register is free or being drained. Reset returns the frame
// state to waiting for a start byte and loads the register defaults.
// ----------------------------------------------------------------------------
module framed_byte_receiver_unit
  import fbr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               byte_ready_i,
  input  logic [ByteW-1:0]   rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               take_byte_o,
  output logic               data_valid_o,
  output logic [ByteW-1:0]   data_index_o,
  output logic [ByteW-1:0]   data_byte_o,
  output logic               status_valid_o,
  output logic [2:0]         status_code_o,
  output logic [ByteW-1:0]   frame_length_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ByteW-1:0]   cfg_data_i
);

  cfg_t             cfg;
  res_t             res;
  res_t             res_q;
  logic             in_valid_q, in_valid_d;
  logic             in_ready_q;
  logic [ByteW-1:0] in_byte_q;
  logic             out_valid_q, out_valid_d;
  logic             advance;
  logic             in_accept;

  fbr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  fbr_frame_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .step_i       (advance),
    .byte_ready_i (in_ready_q),
    .rx_byte_i    (in_byte_q),
    .res_o        (res)
  );

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_ready_q <= byte_ready_i;
      in_byte_q  <= rx_byte_i;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign take_byte_o    = res_q.take_byte;
  assign data_valid_o   = res_q.data_valid;
  assign data_index_o   = res_q.data_index;
  assign data_byte_o    = res_q.data_byte;
  assign status_valid_o = res_q.status_valid;
  assign status_code_o  = res_q.status_code;
  assign frame_length_o = res_q.frame_length;

endmodule

@@ sv/fbr_checker.sv @@
// ----------------------------------------------------------------------------
// fbr_checker
// Port-level checks of the framed byte receiver, bound to the top level.
// ----------------------------------------------------------------------------
module fbr_checker
  import fbr_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic             take_byte_o,
  input logic             data_valid_o,
  input logic [ByteW-1:0] data_index_o,
  input logic [ByteW-1:0] data_byte_o,
  input logic             status_valid_o,
  input logic [2:0]       status_code_o
);

  a_data_or_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(data_valid_o && status_valid_o))
    else $error("data and status in one item");

  a_data_takes_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && data_valid_o) |-> take_byte_o)
    else $error("payload byte delivered without consuming it");

  a_timeout_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_valid_o && status_code_o == ST_TIMEOUT) |-> !take_byte_o)
    else $error("byte consumed on timeout");

  a_idle_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !data_valid_o && !status_valid_o)
      |-> (data_index_o == '0 && data_byte_o == '0 && status_code_o == ST_OK))
    else $error("stale fields in quiet item");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(data_byte_o)
      && $stable(status_code_o)))
    else $error("stalled item changed");

endmodule

bind framed_byte_receiver_unit fbr_checker u_fbr_checker (.*);

@@ tb/frame_result_checker.sv @@
// ----------------------------------------------------------------------------
// frame_result_checker
// Watches the tick, result and register channels of the framed byte receiver,
// predicts one result per accepted tick from its own copy of the frame state
// and the registers, and compares each delivered result field by field with
// the oldest prediction. Hands the count of outstanding predictions and the
// count of failures to the testbench top.
// ----------------------------------------------------------------------------
module frame_result_checker
  import fbr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               byte_ready_i,
  input  logic [ByteW-1:0]   rx_byte_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               take_byte_i,
  input  logic               data_valid_i,
  input  logic [ByteW-1:0]   data_index_i,
  input  logic [ByteW-1:0]   data_byte_i,
  input  logic               status_valid_i,
  input  logic [2:0]         status_code_i,
  input  logic [ByteW-1:0]   frame_length_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ByteW-1:0]   cfg_data_i,
  output int                 pending_o,
  output int                 errors_o
);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LENGTH,
    PH_DATA,
    PH_STUFF,
    PH_CSUM
  } rx_phase_e;

  cfg_t             regs;
  rx_phase_e        phase;
  logic [ByteW-1:0] slot_cnt;
  logic [ByteW-1:0] wait_cnt;
  logic [ByteW-1:0] data_cnt;
  logic [ByteW-1:0] frame_len;
  logic [ByteW-1:0] payload_sum;
  res_t             tick_results[$];
  int               mismatches = 0;

  assign errors_o = mismatches;

  function automatic res_t predict_tick(logic ready, logic [ByteW-1:0] rx);
    res_t r;
    r = '0;
    if (phase == PH_HUNT) begin
      if (ready) begin
        r.take_byte = 1'b1;
        if (rx == regs.start_byte) begin
          wait_cnt = '0;
          phase    = PH_LENGTH;
        end else begin
          r.status_valid = 1'b1;
          r.status_code  = ST_STRAY;
        end
      end
    end else begin
      slot_cnt = slot_cnt + 1'b1;
      if (slot_cnt >= regs.slot_divide) begin
        slot_cnt = '0;
        wait_cnt = wait_cnt + 1'b1;
        if (wait_cnt >= regs.timeout_slots) begin
          r.status_valid = 1'b1;
          r.status_code  = ST_TIMEOUT;
          phase          = PH_HUNT;
        end else if (ready) begin
          r.take_byte = 1'b1;
          wait_cnt    = '0;
          case (phase)
            PH_LENGTH: begin
              frame_len = rx;
              if (rx == '0) begin
                r.status_valid = 1'b1;
                r.status_code  = ST_ZERO_LEN;
                phase          = PH_HUNT;
              end else if (rx > regs.max_length) begin
                r.status_valid = 1'b1;
                r.status_code  = ST_TOO_LONG;
                phase          = PH_HUNT;
              end else begin
                data_cnt    = '0;
                payload_sum = '0;
                phase       = PH_DATA;
              end
            end
            PH_DATA: begin
              r.data_valid = 1'b1;
              r.data_index = data_cnt;
              r.data_byte  = rx;
              payload_sum  = payload_sum + rx;
              data_cnt     = data_cnt + 1'b1;
              if (rx == regs.start_byte) phase = PH_STUFF;
              else if (data_cnt == frame_len) phase = PH_CSUM;
            end
            PH_STUFF: begin
              if (rx != StuffByte) begin
                r.status_valid = 1'b1;
                r.status_code  = ST_BAD_STUFF;
                phase          = PH_HUNT;
              end else if (data_cnt < frame_len) begin
                phase = PH_DATA;
              end else begin
                phase = PH_CSUM;
              end
            end
            default: begin
              r.status_valid = 1'b1;
              r.status_code  = (rx == payload_sum) ? ST_OK : ST_BAD_CSUM;
              phase          = PH_HUNT;
            end
          endcase
        end
      end
    end
    r.frame_length = frame_len;
    return r;
  endfunction

  function automatic void check_field(string name, logic [ByteW-1:0] want,
                                      logic [ByteW-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      regs        = '{RstStartByte, RstMaxLength, RstSlotDivide, RstTimeoutSlots};
      phase       = PH_HUNT;
      slot_cnt    = '0;
      wait_cnt    = '0;
      data_cnt    = '0;
      frame_len   = '0;
      payload_sum = '0;
      tick_results.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (tick_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected, actual take %0d data %0d status %0d",
                   $time, take_byte_i, data_valid_i, status_valid_i);
        end else begin
          want = tick_results.pop_front();
          check_field("take_byte", 8'(want.take_byte), 8'(take_byte_i));
          check_field("data_valid", 8'(want.data_valid), 8'(data_valid_i));
          check_field("data_index", want.data_index, data_index_i);
          check_field("data_byte", want.data_byte, data_byte_i);
          check_field("status_valid", 8'(want.status_valid), 8'(status_valid_i));
          check_field("status_code", 8'(want.status_code), 8'(status_code_i));
          check_field("frame_length", want.frame_length, frame_length_i);
        end
      end
      if (in_valid_i && !in_stall_i)
        tick_results.push_back(predict_tick(byte_ready_i, rx_byte_i));
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_START_BYTE:    regs.start_byte    = cfg_data_i;
          REG_MAX_LENGTH:    regs.max_length    = cfg_data_i;
          REG_SLOT_DIVIDE:   regs.slot_divide   = cfg_data_i;
          REG_TIMEOUT_SLOTS: regs.timeout_slots = cfg_data_i;
        endcase
      end
      pending_o <= tick_results.size();
    end
  end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives the framed byte receiver with time-base ticks: a short directed run
// over every status and the stuffing corners, then random frames with random
// content, broken frames, stray bytes and timeout gaps under several register
// settings, with random gaps on the tick side and random stalls on the result
// side. Checking is done by frame_result_checker.
// ----------------------------------------------------------------------------
module testbench;
  import fbr_pkg::*;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               byte_ready_i;
  logic [ByteW-1:0]   rx_byte_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic               take_byte_o;
  logic               data_valid_o;
  logic [ByteW-1:0]   data_index_o;
  logic [ByteW-1:0]   data_byte_o;
  logic               status_valid_o;
  logic [2:0]         status_code_o;
  logic [ByteW-1:0]   frame_length_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [ByteW-1:0]   cfg_data_i;

  int   pending_cnt;
  int   fail_cnt;
  int   ticks_sent;
  int   send_idle_pct;
  int   recv_idle_pct;
  cfg_t cur_cfg;

  framed_byte_receiver_unit u_dut (.*);

  frame_result_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .byte_ready_i   (byte_ready_i),
    .rx_byte_i      (rx_byte_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .take_byte_i    (take_byte_o),
    .data_valid_i   (data_valid_o),
    .data_index_i   (data_index_o),
    .data_byte_i    (data_byte_o),
    .status_valid_i (status_valid_o),
    .status_code_i  (status_code_o),
    .frame_length_i (frame_length_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .pending_o      (pending_cnt),
    .errors_o       (fail_cnt)
  );

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic send_tick(logic ready, logic [ByteW-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    byte_ready_i <= ready;
    rx_byte_i    <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    ticks_sent++;
  endtask

  // hold the byte for one full slot so exactly one slot tick sees it
  task automatic hold_byte(logic [ByteW-1:0] b);
    repeat (cur_cfg.slot_divide) send_tick(1'b1, b);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [ByteW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_config(cfg_t c);
    drain();
    write_reg(REG_START_BYTE, c.start_byte);
    write_reg(REG_MAX_LENGTH, c.max_length);
    write_reg(REG_SLOT_DIVIDE, c.slot_divide);
    write_reg(REG_TIMEOUT_SLOTS, c.timeout_slots);
    cur_cfg = c;
  endtask

  task automatic send_noise();
    int n;
    case ($urandom_range(7))
      0: begin
        n = cur_cfg.slot_divide * (cur_cfg.timeout_slots + 1);
        if (n > 600) n = 600;
        repeat ($urandom_range(1, n)) send_tick(1'b0, 8'($urandom));
      end
      1: repeat ($urandom_range(1, 3)) send_tick(1'b1, 8'($urandom));
      default: repeat ($urandom_range(0, 3)) send_tick(1'b0, 8'($urandom));
    endcase
  endtask

  task automatic send_frame();
    int               kind;
    int               len;
    int               lmax;
    logic [ByteW-1:0] b;
    logic [ByteW-1:0] sum;
    kind = $urandom_range(9);
    send_tick(1'b1, cur_cfg.start_byte);
    if (kind == 7) begin
      if (cur_cfg.max_length == 8'hFF || $urandom_range(1) == 0) hold_byte(8'h00);
      else hold_byte(8'($urandom_range(cur_cfg.max_length + 1, 255)));
      return;
    end
    lmax = cur_cfg.max_length;
    if (cur_cfg.slot_divide > 8) lmax = 1;
    else if (lmax > 24 && $urandom_range(7) != 0) lmax = 24;
    len = $urandom_range(1, lmax);
    hold_byte(8'(len));
    sum = '0;
    for (int i = 0; i < len; i++) begin
      b = ($urandom_range(4) == 0) ? cur_cfg.start_byte : 8'($urandom);
      hold_byte(b);
      sum = sum + b;
      if (b == cur_cfg.start_byte) begin
        if (kind == 8) begin
          hold_byte(8'($urandom_range(1, 255)));
          return;
        end
        hold_byte(StuffByte);
      end
    end
    // send a wrong checksum for kind 9, and drop the checksum on a truncated frame (kind 6)
    if (kind == 9) hold_byte(sum + 8'($urandom_range(1, 255)));
    else if (kind != 6) hold_byte(sum);
  endtask

  initial begin
    cfg_t c;
    int   goal;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    byte_ready_i  = 1'b0;
    rx_byte_i     = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_START_BYTE;
    cfg_data_i    = '0;
    ticks_sent    = 0;
    send_idle_pct = 28;
    recv_idle_pct = 50;
    cur_cfg       = '{RstStartByte, RstMaxLength, RstSlotDivide, RstTimeoutSlots};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    apply_config('{8'd36, 8'd4, 8'd1, 8'd3});
    send_tick(1'b0, 8'hFF);
    send_tick(1'b1, 8'h00);
    send_tick(1'b1, 8'hFF);
    send_tick(1'b1, 8'd36);
    send_tick(1'b1, 8'd0);
    send_tick(1'b1, 8'd36);
    send_tick(1'b1, 8'd5);
    send_tick(1'b1, 8'd36);
    send_tick(1'b1, 8'd2);
    send_tick(1'b1, 8'hFF);
    send_tick(1'b1, 8'd36);
    send_tick(1'b1, StuffByte);
    send_tick(1'b1, 8'd35);
    send_tick(1'b1, 8'd36);
    send_tick(1'b1, 8'd1);
    send_tick(1'b1, 8'd36);
    send_tick(1'b1, 8'd5);
    send_tick(1'b1, 8'd36);
    send_tick(1'b1, 8'd1);
    send_tick(1'b1, 8'd7);
    send_tick(1'b1, 8'd0);
    send_tick(1'b1, 8'd36);
    repeat (3) send_tick(1'b0, 8'h5A);

    for (int s = 0; s < 7; s++) begin
      case (s)
        0: c = '{RstStartByte, RstMaxLength, RstSlotDivide, RstTimeoutSlots};
        1: c = '{8'h00, 8'hFF, 8'd1, 8'hFF};
        2: c = '{8'hFF, 8'd1, 8'd1, 8'd1};
        3: c = '{8'hA5, 8'd7, 8'd2, 8'd3};
        5: c = '{8'h5A, 8'd8, 8'hFF, 8'd2};
        default: c = '{8'($urandom), 8'($urandom_range(1, 20)), 8'($urandom_range(1, 4)),
                       8'($urandom_range(2, 8))};
      endcase
      apply_config(c);
      if (s < 3) begin
        send_idle_pct = 28;
        recv_idle_pct = 50;
      end else if (s < 5) begin
        send_idle_pct = 50;
        recv_idle_pct = 28;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      goal = ticks_sent + ((s == 5) ? 300 : 60);
      while (ticks_sent < goal) begin
        send_noise();
        send_frame();
      end
    end

    drain();
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
